// ----- rtl/shortest_route_finder_assert.svh -----
// Assertion macros for the route finder checker.
`ifndef SHORTEST_ROUTE_FINDER_ASSERT_SVH
`define SHORTEST_ROUTE_FINDER_ASSERT_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define SRF_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define SRF_ASSERT(name, prop, msg) \
  `SRF_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/srf_pkg.sv -----
// Types, constants and codes shared by the shortest route finder modules.
package srf_pkg;

  localparam int unsigned NODE_COUNT_DEF = 8;
  localparam int unsigned GRAPH_SLOTS    = 8;
  localparam int unsigned NODE_W         = 3;
  localparam int unsigned HOP_W          = 3;
  localparam int unsigned DIST_W         = 4;
  localparam int unsigned ADJ_W          = 64;
  localparam int unsigned PRESENT_W      = 8;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 64;

  localparam logic [DIST_W-1:0] UNREACHED = 4'd15;
  localparam logic [DIST_W-1:0] MAX_LAYER = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADJACENCY = 2'd0,
    REG_PRESENT   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_ROUTE    = 2'd0,
    ST_NO_ROUTE = 2'd1,
    ST_ABSENT   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LAYER,
    S_WALK,
    S_ABSENT,
    S_NO_ROUTE
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_node;
    logic [HOP_W-1:0]  hop_index;
    status_e           status;
    logic              last_in_run;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    search_init;
    logic    layer_step;
    logic    walk_init;
    logic    walk_step;
    logic    emit;
    status_e emit_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic absent;
    logic same;
    logic layer_done;
    logic src_unreached;
    logic walk_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/shortest_route_finder.sv -----
// Shortest route finder top level: sequencer plus datapath.
//
// Each request names a source and a target node of the configured graph.
// The block answers with the shortest route from source to target, one
// result per node, source first, ties going to the route that is smallest
// by node number; a missing node gives one result with status absent, and
// an unreachable target or a source equal to the target gives one result
// with status no-route. Requests are handled one at a time: the block
// takes the request, checks it, runs the breadth-first layer steps and a
// final layering check, then gives one route node per cycle as long as
// the output is not stalled. The sweep stops after the first step that
// finds no new node or after seven steps. A new request is taken as soon
// as the previous one has handed its last result to the output register,
// even while that result waits.
// Write the graph registers only while no request is in flight.
module shortest_route_finder import srf_pkg::*; #(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  req_t                  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rsp_t                  out_rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  srf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  srf_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ----- rtl/srf_ctrl.sv -----
// Query sequencer: check, breadth-first layering, then the forward walk.
module srf_ctrl import srf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // Hold the current phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pick the next phase
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (status_i.absent) state_d = S_ABSENT;
        else if (status_i.same)       state_d = S_NO_ROUTE;
        else                          state_d = S_LAYER;
      end
      S_LAYER: begin
        if (status_i.layer_done) begin
          state_d = status_i.src_unreached ? S_NO_ROUTE : S_WALK;
        end
      end
      S_WALK: begin
        if (status_i.out_free && status_i.walk_last) state_d = S_IDLE;
      end
      S_ABSENT, S_NO_ROUTE: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = ST_ROUTE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.search_init = !status_i.absent && !status_i.same;
      end
      S_LAYER: begin
        cmd_o.layer_step = !status_i.layer_done;
        cmd_o.walk_init  = status_i.layer_done && !status_i.src_unreached;
      end
      S_WALK: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.walk_step = status_i.out_free;
      end
      S_ABSENT: begin
        cmd_o.emit        = status_i.out_free;
        cmd_o.emit_status = ST_ABSENT;
      end
      S_NO_ROUTE: begin
        cmd_o.emit        = status_i.out_free;
        cmd_o.emit_status = ST_NO_ROUTE;
      end
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- rtl/srf_dp.sv -----
// Graph registers, distance layers, forward walk and the result register.
module srf_dp import srf_pkg::*; #(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  req_t                  in_req_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rsp_t                  out_rsp_o
);

  logic [ADJ_W-1:0]      adj_q;
  logic [PRESENT_W-1:0]  present_q;
  logic [NODE_W-1:0]     src_q, dst_q;
  logic [DIST_W-1:0]     dist_q [NODE_COUNT];
  logic [DIST_W-1:0]     dist_d [NODE_COUNT];
  logic [NODE_COUNT-1:0] reached_q, reached_d;
  logic [NODE_COUNT-1:0] frontier_q, frontier_d;
  logic [DIST_W-1:0]     layer_q, layer_d;
  logic [NODE_W-1:0]     pos_q, pos_d;
  logic [HOP_W-1:0]      hop_q, hop_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_rsp_q, out_rsp_d;

  logic [NODE_COUNT-1:0] live;
  logic [NODE_COUNT-1:0] edge_m [NODE_COUNT];
  logic [NODE_COUNT-1:0] dst_hot;
  logic [NODE_COUNT-1:0] nxt;
  logic [NODE_COUNT-1:0] cur_row;
  logic [NODE_COUNT-1:0] cand;
  logic [DIST_W-1:0]     src_dist, cur_dist, want;
  logic [NODE_W-1:0]     pick;
  logic                  src_live, dst_live, has_pick, out_free;

  // Mask presence to the nodes this instance carries
  assign live = present_q[NODE_COUNT-1:0];

  // Build the usable edge matrix: no self loops, both ends present
  always_comb begin
    for (int f = 0; f < NODE_COUNT; f++) begin
      for (int t = 0; t < NODE_COUNT; t++) begin
        edge_m[f][t] = (f != t) && live[f] && live[t] && adj_q[f * GRAPH_SLOTS + t];
      end
    end
  end

  // Look up per-node values for source, target and walk position
  always_comb begin
    src_live = 1'b0;
    dst_live = 1'b0;
    src_dist = UNREACHED;
    cur_dist = UNREACHED;
    cur_row  = '0;
    for (int n = 0; n < NODE_COUNT; n++) begin
      dst_hot[n] = (dst_q == NODE_W'(n));
      if (src_q == NODE_W'(n)) begin
        src_live = live[n];
        src_dist = dist_q[n];
      end
      if (dst_q == NODE_W'(n)) dst_live = live[n];
      if (pos_q == NODE_W'(n)) begin
        cur_dist = dist_q[n];
        cur_row  = edge_m[n];
      end
    end
  end

  // Next breadth-first layer: unreached nodes with an edge into the frontier
  always_comb begin
    for (int n = 0; n < NODE_COUNT; n++) begin
      nxt[n] = !reached_q[n] && |(frontier_q & edge_m[n]);
    end
  end

  // Choose the lowest-numbered neighbour one step closer to the target
  assign want = cur_dist - DIST_W'(1);
  always_comb begin
    pick = '0;
    for (int n = 0; n < NODE_COUNT; n++) begin
      cand[n] = cur_row[n] && (dist_q[n] == want);
    end
    for (int n = NODE_COUNT - 1; n >= 0; n--) begin
      if (cand[n]) pick = NODE_W'(n);
    end
  end
  assign has_pick = |cand;

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.absent        = !(src_live && dst_live);
  assign status_o.same          = (src_q == dst_q);
  assign status_o.layer_done    = (frontier_q == '0) || (layer_q == MAX_LAYER);
  assign status_o.src_unreached = (src_dist == UNREACHED);
  assign status_o.walk_last     = (pos_q == dst_q) || !has_pick || (hop_q == '1);
  assign status_o.out_free      = out_free;

  // Advance search and walk state on command
  always_comb begin
    dist_d     = dist_q;
    reached_d  = reached_q;
    frontier_d = frontier_q;
    layer_d    = layer_q;
    pos_d      = pos_q;
    hop_d      = hop_q;
    if (cmd_i.search_init) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        dist_d[n] = dst_hot[n] ? '0 : UNREACHED;
      end
      reached_d  = dst_hot;
      frontier_d = dst_hot;
      layer_d    = DIST_W'(1);
    end
    if (cmd_i.layer_step) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        if (nxt[n]) dist_d[n] = layer_q;
      end
      reached_d  = reached_q | nxt;
      frontier_d = nxt;
      layer_d    = layer_q + DIST_W'(1);
    end
    if (cmd_i.walk_init) begin
      pos_d = src_q;
      hop_d = '0;
    end
    if (cmd_i.walk_step) begin
      pos_d = pick;
      hop_d = hop_q + HOP_W'(1);
    end
  end

  // Load the result register; drop the valid once the result is taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (cmd_i.emit_status == ST_ROUTE) begin
        out_rsp_d.path_node   = pos_q;
        out_rsp_d.hop_index   = hop_q;
        out_rsp_d.status      = ST_ROUTE;
        out_rsp_d.last_in_run = status_o.walk_last;
      end else begin
        out_rsp_d.path_node   = '0;
        out_rsp_d.hop_index   = '0;
        out_rsp_d.status      = cmd_i.emit_status;
        out_rsp_d.last_in_run = 1'b1;
      end
    end
  end

  // Hold configuration and the result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q       <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ADJACENCY: adj_q     <= cfg_wdata_i[ADJ_W-1:0];
          REG_PRESENT:   present_q <= cfg_wdata_i[PRESENT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Hold per-request scratch and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q <= in_req_i.source_node;
      dst_q <= in_req_i.target_node;
    end
    dist_q     <= dist_d;
    reached_q  <= reached_d;
    frontier_q <= frontier_d;
    layer_q    <= layer_d;
    pos_q      <= pos_d;
    hop_q      <= hop_d;
    out_rsp_q  <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- rtl/srf_checker.sv -----
// Port-level checks for the shortest route finder, bound to the top level.
`include "shortest_route_finder_assert.svh"

module srf_checker import srf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  // A taken request occupies the block for at least the next cycle
  `SRF_ASSERT(a_busy_after_request, in_valid_i && !in_stall_o |=> in_stall_o, "request not held busy")

  // Status results end their request
  `SRF_ASSERT(a_status_is_last, out_valid_o && (out_rsp_o.status != ST_ROUTE) |-> out_rsp_o.last_in_run, "status result not last")

  // Status results carry no node and no hop
  `SRF_ASSERT(a_status_zero, out_valid_o && (out_rsp_o.status != ST_ROUTE) |-> (out_rsp_o.path_node == '0) && (out_rsp_o.hop_index == '0), "status result not zeroed")

  // A stalled result stays put
  `SRF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o), "stalled result changed")

endmodule

bind shortest_route_finder srf_checker u_srf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the shortest route finder: directed and random route queries.
module testbench;
  import srf_pkg::*;

  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 42;
  localparam int unsigned IDLE_PCT      = 26;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DRAIN_CYCLES  = 30;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  // Index with no register behind it; writes there must leave the graph alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  req_t                  in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rsp_t                  out_rsp_o;

  // Shadow copy of the graph registers
  logic [ADJ_W-1:0]     graph_edges = '0;
  logic [PRESENT_W-1:0] graph_nodes = '0;
  logic [NODE_W-1:0]    chain_order [GRAPH_SLOTS];

  req_t pending_requests [$];
  rsp_t awaited_route_nodes [$];

  bit calm         = 1'b0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int sent         = 0;
  int checked      = 0;
  int mismatches   = 0;
  int cycle_count  = 0;
  int graphs_used  = 0;

  shortest_route_finder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Edge counts only when both ends are present, distinct and the bit is set
  function automatic bit link_live(logic [NODE_W-1:0] from_n, logic [NODE_W-1:0] to_n);
    if (from_n == to_n) return 1'b0;
    if (!graph_nodes[from_n] || !graph_nodes[to_n]) return 1'b0;
    return graph_edges[{from_n, to_n}];
  endfunction

  function automatic void push_route_node(logic [NODE_W-1:0] node, logic [HOP_W-1:0] hop,
                                          status_e st, logic last);
    rsp_t r;
    r.path_node   = node;
    r.hop_index   = hop;
    r.status      = st;
    r.last_in_run = last;
    awaited_route_nodes = {awaited_route_nodes, r};
  endfunction

  // Layer distances towards the target, then walk greedily from the source
  function automatic void predict_route(req_t req);
    logic [DIST_W-1:0] reach_hops [GRAPH_SLOTS];
    logic [7:0]        reached;
    logic [7:0]        frontier;
    logic [7:0]        layer;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [NODE_W-1:0] here;
    logic [NODE_W-1:0] pick;
    bit                found;
    logic              last;
    src = req.source_node;
    dst = req.target_node;
    if (!graph_nodes[src] || !graph_nodes[dst]) begin
      push_route_node('0, '0, ST_ABSENT, 1'b1);
      return;
    end
    if (src == dst) begin
      push_route_node('0, '0, ST_NO_ROUTE, 1'b1);
      return;
    end
    for (int i = 0; i < GRAPH_SLOTS; i++) reach_hops[i] = UNREACHED;
    reach_hops[dst] = '0;
    reached   = 8'(1) << dst;
    frontier  = reached;
    for (int d = 1; d < GRAPH_SLOTS && frontier != 0; d++) begin
      layer = '0;
      for (int n = 0; n < GRAPH_SLOTS; n++) begin
        if (reached[n]) continue;
        for (int m = 0; m < GRAPH_SLOTS; m++) begin
          if (frontier[m] && link_live(NODE_W'(n), NODE_W'(m))) begin
            layer[n]      = 1'b1;
            reach_hops[n] = DIST_W'(d);
            break;
          end
        end
      end
      reached  = reached | layer;
      frontier = layer;
    end
    if (reach_hops[src] == UNREACHED) begin
      push_route_node('0, '0, ST_NO_ROUTE, 1'b1);
      return;
    end
    here = src;
    for (int hops = 0; hops < GRAPH_SLOTS; hops++) begin
      found = 1'b0;
      pick  = '0;
      if (here != dst) begin
        for (int n = 0; n < GRAPH_SLOTS; n++) begin
          if (reach_hops[n] == reach_hops[here] - 4'd1 && link_live(here, NODE_W'(n))) begin
            pick  = NODE_W'(n);
            found = 1'b1;
            break;
          end
        end
      end
      last = (hops == GRAPH_SLOTS - 1) ? (here == dst) : !found;
      push_route_node(here, HOP_W'(hops), ST_ROUTE, last);
      if (!found || hops == GRAPH_SLOTS - 1) return;
      here = pick;
    end
  endfunction

  // Request driver: hold the payload while stalled, otherwise offer the next or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_route(in_req_i);
        sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_req_i   <= pending_requests.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result stall: random back-pressure, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES;
        out_stall_i  <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_route_nodes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: node %0d hop %0d status %0d last %0d",
                   out_rsp_o.path_node, out_rsp_o.hop_index, out_rsp_o.status,
                   out_rsp_o.last_in_run);
      end else begin
        want = awaited_route_nodes.pop_front();
        checked++;
        if (out_rsp_o.path_node !== want.path_node || out_rsp_o.hop_index !== want.hop_index ||
            out_rsp_o.status !== want.status || out_rsp_o.last_in_run !== want.last_in_run) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected node %0d hop %0d status %0d last %0d, ",
                      "got node %0d hop %0d status %0d last %0d"},
                     want.path_node, want.hop_index, want.status, want.last_in_run,
                     out_rsp_o.path_node, out_rsp_o.hop_index, out_rsp_o.status,
                     out_rsp_o.last_in_run);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("shortest_route_finder test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ADJACENCY) graph_edges = value;
    else if (idx == REG_PRESENT) graph_nodes = value[PRESENT_W-1:0];
  endtask

  task automatic load_graph(logic [ADJ_W-1:0] adj, logic [PRESENT_W-1:0] nodes);
    write_reg(REG_ADJACENCY, adj);
    write_reg(REG_PRESENT, CFG_DATA_W'(nodes));
    graphs_used++;
  endtask

  task automatic add_query(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    req_t r;
    r.source_node = src;
    r.target_node = dst;
    pending_requests = {pending_requests, r};
  endtask

  // Wait until the block has drained every request and result
  task automatic settle();
    while (pending_requests.size() != 0 || in_valid_i || awaited_route_nodes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [NODE_W-1:0] any_present_node();
    logic [NODE_W-1:0] n;
    n = NODE_W'($urandom_range(GRAPH_SLOTS - 1));
    while (!graph_nodes[n]) n = NODE_W'($urandom_range(GRAPH_SLOTS - 1));
    return n;
  endfunction

  // Random graph for one phase: chains reach long routes, densities vary
  task automatic pick_graph(int phase);
    logic [ADJ_W-1:0]     adj;
    logic [PRESENT_W-1:0] nodes;
    logic [NODE_W-1:0]    tmp;
    int                   j;
    for (int i = 0; i < GRAPH_SLOTS; i++) chain_order[i] = NODE_W'(i);
    for (int i = GRAPH_SLOTS - 1; i > 0; i--) begin
      j              = $urandom_range(i);
      tmp            = chain_order[i];
      chain_order[i] = chain_order[j];
      chain_order[j] = tmp;
    end
    unique case (phase % 4)
      0: begin
        adj = {$urandom & $urandom & $urandom & $urandom,
               $urandom & $urandom & $urandom & $urandom};
        for (int i = 0; i < GRAPH_SLOTS - 1; i++) adj[{chain_order[i], chain_order[i+1]}] = 1'b1;
        nodes = '1;
      end
      1: begin
        adj   = {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
        nodes = PRESENT_W'($urandom | $urandom);
      end
      2: begin
        adj   = {$urandom | $urandom, $urandom | $urandom};
        nodes = PRESENT_W'($urandom | $urandom | $urandom);
      end
      default: begin
        adj   = {$urandom, $urandom};
        nodes = PRESENT_W'($urandom | $urandom);
      end
    endcase
    if ($countones(nodes) < 2) nodes = '1;
    load_graph(adj, nodes);
  endtask

  // Mostly queries between present nodes, some along the chain, the rest noise
  task automatic queue_random_queries(bit chain_like);
    int roll;
    int a;
    int b;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      roll = $urandom_range(99);
      if (chain_like && roll < 40) begin
        a = $urandom_range(GRAPH_SLOTS - 2);
        b = $urandom_range(GRAPH_SLOTS - 1, a + 1);
        add_query(chain_order[a], chain_order[b]);
      end else if (roll < 85) begin
        add_query(any_present_node(), any_present_node());
      end else begin
        add_query(NODE_W'($urandom), NODE_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [ADJ_W-1:0] adj;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty graph after reset: every node is absent
    add_query(3'd0, 3'd7);
    add_query(3'd7, 3'd0);
    add_query(3'd3, 3'd3);
    settle();

    // Full-length chain with self-loops on every node
    adj = '0;
    for (int i = 0; i < GRAPH_SLOTS; i++) begin
      adj[{NODE_W'(i), NODE_W'(i)}] = 1'b1;
      if (i < GRAPH_SLOTS - 1) adj[{NODE_W'(i), NODE_W'(i + 1)}] = 1'b1;
    end
    load_graph(adj, '1);
    add_query(3'd0, 3'd7);
    add_query(3'd7, 3'd0);
    add_query(3'd3, 3'd3);
    add_query(3'd2, 3'd5);
    settle();

    // Ties and a shortcut through an absent node
    adj = '0;
    adj[{3'd0, 3'd5}] = 1'b1;
    adj[{3'd5, 3'd7}] = 1'b1;
    adj[{3'd0, 3'd2}] = 1'b1;
    adj[{3'd2, 3'd3}] = 1'b1;
    adj[{3'd3, 3'd7}] = 1'b1;
    adj[{3'd0, 3'd1}] = 1'b1;
    adj[{3'd1, 3'd3}] = 1'b1;
    load_graph(adj, 8'hDF);
    write_reg(REG_SPARE, '1);
    add_query(3'd0, 3'd7);
    add_query(3'd5, 3'd7);
    add_query(3'd0, 3'd5);
    add_query(3'd6, 3'd0);
    add_query(3'd1, 3'd3);
    settle();

    // Complete graph, then only the two end nodes present
    load_graph('1, '1);
    add_query(3'd7, 3'd0);
    add_query(3'd0, 3'd7);
    add_query(3'd4, 3'd4);
    settle();
    load_graph('1, 8'h81);
    add_query(3'd0, 3'd7);
    add_query(3'd7, 3'd1);
    settle();

    // Random graphs; one phase without idling, two with a long result hold-off
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_graph(phase);
      calm = (phase == 4);
      if (phase == 1 || phase == 5) holds_asked++;
      queue_random_queries(phase % 4 == 0);
      settle();
    end
    calm = 1'b0;

    $display("Ran %0d route queries over %0d graph settings, %0d results checked.",
             sent, graphs_used, checked);
    $display("Long result hold-offs: %0d, mismatches: %0d.", holds_served, mismatches);
    if (mismatches == 0 && awaited_route_nodes.size() == 0) begin
      $display("shortest_route_finder test passed");
    end else begin
      $display("shortest_route_finder test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/srf_pkg.sv
rtl/srf_ctrl.sv
rtl/srf_dp.sv
rtl/shortest_route_finder.sv
rtl/srf_checker.sv
tb/sv/testbench.sv
